[hw/rtl/round_robin_task_scheduler_semaphores_defines.svh]
// Assertion helpers shared by the scheduler RTL.
// Each expects clk and rst to be visible where it is used.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_SEMAPHORES_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_SEMAPHORES_DEFINES_SVH

// Same-cycle implication.
`define RRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rrs_pkg.sv]
`default_nettype none

package rrs_pkg;

  // Default configuration
  localparam int DEF_NUM_TASKS   = 8;
  localparam int DEF_NUM_SEMS    = 4;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TICK_WIDTH  = 32;

  // Semaphore count limits (16-bit signed)
  localparam logic [15:0] SEM_MAX = 16'h7FFF;
  localparam logic [15:0] SEM_MIN = 16'h8000;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_SCHED  = 3'd1,
    CMD_SLEEP  = 3'd2,
    CMD_WAIT   = 3'd3,
    CMD_SIGNAL = 3'd4,
    CMD_INIT   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_TAKE,
    ST_WAKE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_LE,
    ALU_SAT_INC,
    ALU_SAT_DEC
  } alu_op_t;

endpackage

`default_nettype wire

[hw/rtl/round_robin_task_scheduler_semaphores.sv]
// Round-robin task scheduler with counting semaphores. Each command on the input channel
// (tick, schedule, sleep, semaphore wait, signal, init) yields exactly one result transaction
// reporting the running task, idle/blocked/woken status and the addressed semaphore count.
// The block handles one command at a time and drops in_ready while busy; the result sits in
// an output register, so the next command is accepted once the result has been loaded there.
// Tick, sleep, wait, init and the unused codes pass through EXEC to DONE; signal also passes
// through WAKE when its queue is not empty, and schedule passes through SCAN and, when the
// selected task has a deferred take, TAKE: the scan visits one task per cycle through a
// single shared compare unit and a registered read of the wake-time memory. Semaphore
// counts saturate at 16-bit signed limits; each wait queue holds QUEUE_DEPTH - 1 tasks.
`default_nettype none
`include "round_robin_task_scheduler_semaphores_defines.svh"

module round_robin_task_scheduler_semaphores import rrs_pkg::*; #(
  parameter int NUM_TASKS   = DEF_NUM_TASKS,
  parameter int NUM_SEMS    = DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TICK_WIDTH  = DEF_TICK_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [1:0]  sem_index,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       running_task,
  output logic             idle,
  output logic             caller_blocked,
  output logic [2:0]       woken_task,
  output logic             woken_valid,
  output logic [15:0]      sem_count_now
);

  localparam int TW       = $clog2(NUM_TASKS);
  localparam int SW       = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QW       = $clog2(QUEUE_DEPTH);
  localparam int WQ_DEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int WAW      = $clog2(WQ_DEPTH);

  // Wrap helpers
  function automatic logic [TW-1:0] task_nxt(input logic [TW-1:0] x);
    return (x == TW'(NUM_TASKS - 1)) ? '0 : x + TW'(1);
  endfunction

  function automatic logic [QW-1:0] ptr_nxt(input logic [QW-1:0] x);
    return (x == QW'(QUEUE_DEPTH - 1)) ? '0 : x + QW'(1);
  endfunction

  state_t state, state_next;

  // Command transaction
  cmd_t        cmd_q;
  logic [1:0]  sem_q;
  logic [15:0] val_q;

  // Scheduler state
  logic [TW-1:0]         cur;
  logic [TICK_WIDTH-1:0] tick;
  logic [NUM_TASKS-1:0]  ready_f;
  logic [NUM_TASKS-1:0]  sleep_f;
  logic [NUM_TASKS-1:0]  pend_f;
  logic [15:0]           cnt [NUM_SEMS];
  logic [QW-1:0]         inp [NUM_SEMS];
  logic [QW-1:0]         outp [NUM_SEMS];

  // Scan and result working registers
  logic [TW-1:0] scan_t;
  logic [TW-1:0] scan_cnt;
  logic          r_idle;
  logic          r_blk;
  logic          r_wok;
  logic [TW-1:0] r_woken;

  // Memories
  logic [TICK_WIDTH-1:0] wake_mem [NUM_TASKS];
  logic [TICK_WIDTH-1:0] wake_rd;
  logic [TW-1:0]         wake_raddr;
  logic [SW-1:0]         psem_mem [NUM_TASKS];
  logic [SW-1:0]         psem_rd;
  logic [TW-1:0]         wq_mem [WQ_DEPTH];
  logic [TW-1:0]         wq_rd;
  logic [WAW-1:0]        wq_waddr;
  logic [WAW-1:0]        wq_raddr;
  logic                  wq_we;

  // Shared unit
  alu_op_t               alu_op;
  logic [TICK_WIDTH-1:0] alu_a;
  logic [TICK_WIDTH-1:0] alu_b;
  logic [TICK_WIDTH-1:0] alu_res;
  logic                  alu_le;

  // Decoded conditions
  logic [SW-1:0] s;
  logic [SW-1:0] sem_sel;
  logic [15:0]   cnt_rd;
  logic          sem_ok;
  logic          cnt_le0;
  logic [QW-1:0] q_nx;
  logic          q_full;
  logic          q_nonempty;
  logic          elig;
  logic          scan_last;
  logic          out_free;
  logic          wait_block;

  assign s          = SW'(sem_q);
  assign sem_ok     = (32'(sem_q) < 32'(NUM_SEMS));
  assign sem_sel    = (state == ST_TAKE) ? psem_rd : s;
  assign cnt_rd     = cnt[sem_sel];
  assign cnt_le0    = cnt_rd[15] || (cnt_rd == 16'd0);
  assign q_nx       = ptr_nxt(inp[s]);
  assign q_full     = (q_nx == outp[s]);
  assign q_nonempty = (inp[s] != outp[s]);
  assign elig       = ready_f[scan_t] && (!sleep_f[scan_t] || alu_le);
  assign scan_last  = (scan_cnt == TW'(NUM_TASKS - 1));
  assign out_free   = !out_valid || out_ready;
  assign wait_block = (state == ST_EXEC) && (cmd_q == CMD_WAIT) && sem_ok && cnt_le0 && !q_full;

  assign in_ready   = (state == ST_IDLE);
  assign wake_raddr = task_nxt((state == ST_SCAN) ? scan_t : cur);
  assign wq_we      = wait_block;
  assign wq_waddr   = WAW'(s) * WAW'(QUEUE_DEPTH) + WAW'(inp[s]);
  assign wq_raddr   = WAW'(s) * WAW'(QUEUE_DEPTH) + WAW'(outp[s]);

  rrs_alu #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .le  (alu_le)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_q == CMD_SCHED) begin
          state_next = ST_SCAN;
        end else if ((cmd_q == CMD_SIGNAL) && sem_ok && q_nonempty) begin
          state_next = ST_WAKE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (elig) begin
          state_next = pend_f[scan_t] ? ST_TAKE : ST_DONE;
        end else if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_TAKE: state_next = ST_DONE;
      ST_WAKE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Shared unit operand selection
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      ST_EXEC: begin
        priority case (cmd_q)
          CMD_TICK: begin
            alu_a = tick;
            alu_b = TICK_WIDTH'(1);
          end
          CMD_SLEEP: begin
            alu_a = tick;
            alu_b = TICK_WIDTH'(val_q);
          end
          CMD_WAIT: begin
            alu_op = ALU_SAT_DEC;
            alu_a  = TICK_WIDTH'(cnt_rd);
          end
          CMD_SIGNAL: begin
            alu_op = ALU_SAT_INC;
            alu_a  = TICK_WIDTH'(cnt_rd);
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        alu_op = ALU_LE;
        alu_a  = wake_rd;
        alu_b  = tick;
      end
      ST_TAKE: begin
        alu_op = ALU_SAT_DEC;
        alu_a  = TICK_WIDTH'(cnt_rd);
      end
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      tick      <= '0;
      ready_f   <= '1;
      sleep_f   <= '0;
      pend_f    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        cnt[i]  <= '0;
        inp[i]  <= '0;
        outp[i] <= '0;
      end
    end else begin
      state <= state_next;
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd_t'(command);
            sem_q   <= sem_index;
            val_q   <= value;
            r_idle  <= 1'b0;
            r_blk   <= 1'b0;
            r_wok   <= 1'b0;
            r_woken <= '0;
          end
        end
        ST_EXEC: begin
          priority case (cmd_q)
            CMD_TICK: tick <= alu_res;
            CMD_SCHED: begin
              scan_t   <= task_nxt(cur);
              scan_cnt <= '0;
            end
            CMD_SLEEP: begin
              sleep_f[cur] <= 1'b1;
              r_blk        <= 1'b1;
            end
            CMD_WAIT: begin
              if (sem_ok) begin
                if (cnt_le0) begin
                  if (!q_full) begin
                    inp[s]       <= q_nx;
                    ready_f[cur] <= 1'b0;
                    pend_f[cur]  <= 1'b1;
                    r_blk        <= 1'b1;
                  end
                end else begin
                  cnt[s] <= alu_res[15:0];
                end
              end
            end
            CMD_SIGNAL: begin
              if (sem_ok) cnt[s] <= alu_res[15:0];
            end
            CMD_INIT: begin
              if (sem_ok) cnt[s] <= val_q;
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          scan_t   <= task_nxt(scan_t);
          scan_cnt <= scan_cnt + TW'(1);
          if (elig) begin
            sleep_f[scan_t] <= 1'b0;
            cur             <= scan_t;
          end else if (scan_last) begin
            r_idle <= 1'b1;
          end
        end
        ST_TAKE: begin
          cnt[psem_rd] <= alu_res[15:0];
          pend_f[cur]  <= 1'b0;
        end
        ST_WAKE: begin
          ready_f[wq_rd] <= 1'b1;
          outp[s]        <= ptr_nxt(outp[s]);
          r_wok          <= 1'b1;
          r_woken        <= wq_rd;
        end
        ST_DONE: begin
          if (out_free) begin
            running_task   <= 3'(cur);
            idle           <= r_idle;
            caller_blocked <= r_blk;
            woken_task     <= 3'(r_woken);
            woken_valid    <= r_wok;
            sem_count_now  <= sem_ok ? cnt_rd : 16'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Wake-time memory: written by sleep, read along the scan
  always_ff @(posedge clk) begin
    if ((state == ST_EXEC) && (cmd_q == CMD_SLEEP)) wake_mem[cur] <= alu_res;
    wake_rd <= wake_mem[wake_raddr];
  end

  // Pending-semaphore memory: read for the task under evaluation
  always_ff @(posedge clk) begin
    if (wait_block) psem_mem[cur] <= s;
    psem_rd <= psem_mem[scan_t];
  end

  // Wait queues, one region of QUEUE_DEPTH slots per semaphore
  always_ff @(posedge clk) begin
    if (wq_we) wq_mem[wq_waddr] <= cur;
    wq_rd <= wq_mem[wq_raddr];
  end

  // Checks
  `RRS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "input accepted while a command is in progress")
  `RRS_ASSERT_NOW(a_wake_excl, out_valid && woken_valid, !caller_blocked && !idle,
                  "signal result also reports blocked or idle")
  `RRS_ASSERT_NOW(a_cur_range, 1'b1, cur <= TW'(NUM_TASKS - 1),
                  "running task index out of range")
  `RRS_ASSERT_NOW(a_take_from_scan, state == ST_TAKE, $past(state) == ST_SCAN,
                  "deferred take outside a schedule")

endmodule

`default_nettype wire

[hw/rtl/rrs_alu.sv]
`default_nettype none

// Shared arithmetic unit: tick add, wake-time compare, saturating count step
module rrs_alu import rrs_pkg::*; #(
  parameter int TICK_WIDTH = DEF_TICK_WIDTH
) (
  input  wire alu_op_t               op,
  input  wire logic [TICK_WIDTH-1:0] a,
  input  wire logic [TICK_WIDTH-1:0] b,
  output logic      [TICK_WIDTH-1:0] res,
  output logic                       le
);

  logic [15:0] cnt;

  assign cnt = a[15:0];

  always_comb begin
    res = a + b;
    le  = (a <= b);
    unique case (op)
      ALU_ADD:     res = a + b;
      ALU_LE:      res = '0;
      ALU_SAT_INC: res = TICK_WIDTH'((cnt == SEM_MAX) ? cnt : cnt + 16'd1);
      ALU_SAT_DEC: res = TICK_WIDTH'((cnt == SEM_MIN) ? cnt : cnt - 16'd1);
      default:     res = a + b;
    endcase
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rrs_pkg::*;

  localparam int NTASK  = DEF_NUM_TASKS;
  localparam int NSEM   = DEF_NUM_SEMS;
  localparam int QDEPTH = DEF_QUEUE_DEPTH;

  // spare command codes, no operation
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // random burst flavors
  localparam int BURST_MIXED    = 0;
  localparam int BURST_BLOCKING = 1;
  localparam int BURST_WAKING   = 2;
  localparam int BURST_TIMED    = 3;

  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [2:0]  running_task;
    logic        idle;
    logic        caller_blocked;
    logic [2:0]  woken_task;
    logic        woken_valid;
    logic [15:0] sem_count_now;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = CMD_TICK;
  logic [1:0]  sem_index = 2'd0;
  logic [15:0] value = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  running_task;
  logic        idle;
  logic        caller_blocked;
  logic [2:0]  woken_task;
  logic        woken_valid;
  logic [15:0] sem_count_now;

  int fail_count    = 0;
  int send_gap_pct  = 0;
  int stall_pct     = 0;
  int hold_req_len  = 0;
  int hold_req_id   = 0;
  int hold_seen_id  = 0;
  int hold_left     = 0;

  sched_result_t sched_outcomes_q[$];

  // shadow scheduler state
  bit          m_ready[NTASK];
  bit          m_sleeping[NTASK];
  logic [31:0] m_wake[NTASK];
  bit          m_take[NTASK];
  logic [1:0]  m_take_sem[NTASK];
  logic [2:0]  m_cur;
  logic [31:0] m_ticks;
  int          m_count[NSEM];
  logic [2:0]  m_waitq[NSEM][QDEPTH];
  int          m_qin[NSEM];
  int          m_qout[NSEM];

  round_robin_task_scheduler_semaphores i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .sem_index      (sem_index),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .running_task   (running_task),
    .idle           (idle),
    .caller_blocked (caller_blocked),
    .woken_task     (woken_task),
    .woken_valid    (woken_valid),
    .sem_count_now  (sem_count_now)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id = hold_req_id;
      hold_left = hold_req_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int sat16(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic void reset_sched_state();
    for (int t = 0; t < NTASK; t++) begin
      m_ready[t] = 1'b1;
      m_sleeping[t] = 1'b0;
      m_wake[t] = '0;
      m_take[t] = 1'b0;
      m_take_sem[t] = '0;
    end
    m_cur = '0;
    m_ticks = '0;
    for (int s = 0; s < NSEM; s++) begin
      m_count[s] = 0;
      m_qin[s] = 0;
      m_qout[s] = 0;
    end
  endfunction

  // apply one command to the shadow state, return the outcome it reports
  function automatic sched_result_t run_command(logic [2:0] cmd, logic [1:0] sem,
                                                logic [15:0] val);
    sched_result_t r;
    int cur;
    int t;
    int nx;
    bit found;
    r = '{default: '0};
    cur = m_cur;
    case (cmd)
      CMD_TICK: m_ticks = m_ticks + 32'd1;
      CMD_SCHED: begin
        // round-robin from the next task; the running one comes last
        found = 1'b0;
        for (int i = 1; i <= NTASK && !found; i++) begin
          t = (cur + i) % NTASK;
          if (!m_ready[t]) continue;
          if (m_sleeping[t]) begin
            if (m_wake[t] <= m_ticks) m_sleeping[t] = 1'b0;
            else continue;
          end
          found = 1'b1;
          m_cur = 3'(t);
          // deferred take of an earlier blocking wait
          if (m_take[t]) begin
            m_count[m_take_sem[t]] = sat16(m_count[m_take_sem[t]] - 1);
            m_take[t] = 1'b0;
          end
        end
        r.idle = !found;
      end
      CMD_SLEEP: begin
        m_wake[cur] = m_ticks + {16'd0, val};
        m_sleeping[cur] = 1'b1;
        r.caller_blocked = 1'b1;
      end
      CMD_WAIT: begin
        if (m_count[sem] <= 0) begin
          nx = (m_qin[sem] + 1) % QDEPTH;
          // full queue: nothing happens
          if (nx != m_qout[sem]) begin
            m_waitq[sem][m_qin[sem]] = 3'(cur);
            m_qin[sem] = nx;
            m_ready[cur] = 1'b0;
            m_take[cur] = 1'b1;
            m_take_sem[cur] = sem;
            r.caller_blocked = 1'b1;
          end
        end else begin
          m_count[sem] = sat16(m_count[sem] - 1);
        end
      end
      CMD_SIGNAL: begin
        m_count[sem] = sat16(m_count[sem] + 1);
        if (m_qin[sem] != m_qout[sem]) begin
          t = m_waitq[sem][m_qout[sem]];
          m_ready[t] = 1'b1;
          m_qout[sem] = (m_qout[sem] + 1) % QDEPTH;
          r.woken_task = 3'(t);
          r.woken_valid = 1'b1;
        end
      end
      CMD_INIT: m_count[sem] = int'($signed(val));
      default: ;
    endcase
    r.running_task = m_cur;
    r.sem_count_now = m_count[sem][15:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    sched_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (sched_outcomes_q.size() == 0) begin
        $error("result transaction with no command outstanding");
        fail_count++;
      end else begin
        want = sched_outcomes_q.pop_front();
        check_field("running_task", want.running_task, running_task);
        check_field("idle", want.idle, idle);
        check_field("caller_blocked", want.caller_blocked, caller_blocked);
        check_field("woken_task", want.woken_task, woken_task);
        check_field("woken_valid", want.woken_valid, woken_valid);
        check_field("sem_count_now", want.sem_count_now, sem_count_now);
      end
    end
  end

  // one command transaction; starts and ends at a falling edge
  task automatic send_cmd(input logic [2:0] cmd, input logic [1:0] sem,
                          input logic [15:0] val);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    sem_index <= sem;
    value     <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sched_outcomes_q.push_back(run_command(cmd, sem, val));
    @(negedge clk);
  endtask

  // sender goes quiet until every expected result has come
  task automatic wait_results_drained();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (sched_outcomes_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (sched_outcomes_q.size() != 0) begin
      $error("%0d results never arrived", sched_outcomes_q.size());
      fail_count++;
      sched_outcomes_q.delete();
    end
  endtask

  function automatic logic [2:0] pick_command(int mode);
    int r;
    int w[6];
    int acc;
    r = $urandom_range(99);
    case (mode)
      BURST_BLOCKING: w = '{5, 20, 3, 55, 10, 5};
      BURST_WAKING:   w = '{10, 30, 3, 10, 40, 5};
      BURST_TIMED:    w = '{40, 30, 20, 3, 3, 2};
      default:        w = '{18, 25, 10, 18, 18, 9};
    endcase
    acc = 0;
    for (int k = 0; k < 6; k++) begin
      acc += w[k];
      if (r < acc) return 3'(k);
    end
    return (r[0]) ? CMD_SPARE_7 : CMD_SPARE_6;
  endfunction

  task automatic send_random_item(input int mode, input logic [1:0] focus);
    logic [2:0]  cmd;
    logic [1:0]  sem;
    logic [15:0] val;
    int          iv;
    cmd = pick_command(mode);
    sem = ($urandom_range(99) < 75) ? focus : 2'($urandom_range(3));
    val = 16'($urandom);
    if (cmd == CMD_SLEEP && $urandom_range(99) != 0) begin
      val = 16'($urandom_range(0, 24));
    end else if (cmd == CMD_INIT && $urandom_range(9) != 0) begin
      iv = int'($urandom_range(0, 5)) - 2;
      val = iv[15:0];
    end
    send_cmd(cmd, sem, val);
  endtask

  task automatic set_traffic(input int gap, input int stall);
    send_gap_pct = gap;
    stall_pct = stall;
  endtask

  // field extremes, spare codes, saturation high, far and due sleepers
  task automatic test_directed_ops();
    send_cmd(CMD_TICK, 2'd0, 16'd0);
    send_cmd(CMD_SPARE_6, 2'd3, 16'hFFFF);
    send_cmd(CMD_SPARE_7, 2'd0, 16'd0);
    send_cmd(CMD_INIT, 2'd3, 16'h7FFF);
    send_cmd(CMD_SIGNAL, 2'd3, 16'd0);
    send_cmd(CMD_WAIT, 2'd3, 16'd0);
    send_cmd(CMD_INIT, 2'd2, 16'h8000);
    send_cmd(CMD_SLEEP, 2'd0, 16'hFFFF);
    send_cmd(CMD_SCHED, 2'd0, 16'd0);
    send_cmd(CMD_SLEEP, 2'd1, 16'd0);
    send_cmd(CMD_TICK, 2'd1, 16'd0);
    send_cmd(CMD_SCHED, 2'd2, 16'd0);
  endtask

  // blocking wait, repeated wait, init with waiters, deferred take saturating low
  task automatic test_deferred_take();
    send_cmd(CMD_WAIT, 2'd0, 16'd0);
    send_cmd(CMD_WAIT, 2'd0, 16'd0);
    send_cmd(CMD_SCHED, 2'd0, 16'd0);
    send_cmd(CMD_SIGNAL, 2'd0, 16'd0);
    send_cmd(CMD_INIT, 2'd0, 16'h8000);
    repeat (8) send_cmd(CMD_SCHED, 2'd0, 16'd0);
  endtask

  // fill one wait queue past capacity, then drain it
  task automatic test_queue_full();
    set_traffic(30, 30);
    send_cmd(CMD_INIT, 2'd1, 16'd0);
    repeat (QDEPTH) send_cmd(CMD_WAIT, 2'd1, 16'd0);
    send_cmd(CMD_SCHED, 2'd1, 16'd0);
    repeat (QDEPTH) send_cmd(CMD_SIGNAL, 2'd1, 16'd0);
    send_cmd(CMD_SCHED, 2'd1, 16'd0);
  endtask

  // long receiver hold-off while commands keep coming, then a full pause
  task automatic test_backpressure();
    set_traffic(0, 0);
    wait_results_drained();
    hold_req_len = 150;
    hold_req_id++;
    repeat (12) send_random_item(BURST_MIXED, 2'($urandom_range(3)));
    wait_results_drained();
    repeat (8) send_random_item(BURST_MIXED, 2'($urandom_range(3)));
  endtask

  task automatic run_random_phase(input int n);
    int sent;
    int mode;
    int len;
    logic [1:0] focus;
    sent = 0;
    while (sent < n) begin
      mode = $urandom_range(3);
      focus = 2'($urandom_range(3));
      len = $urandom_range(10, 60);
      for (int k = 0; k < len && sent < n; k++) begin
        send_random_item(mode, focus);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    set_traffic(0, 0);
    run_random_phase(410);
    wait_results_drained();
    set_traffic(67, 0);
    run_random_phase(410);
    wait_results_drained();
    set_traffic(0, 67);
    run_random_phase(410);
    wait_results_drained();
    set_traffic(30, 30);
    run_random_phase(420);
  endtask

  initial begin
    reset_sched_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_ops();
    test_deferred_take();
    test_queue_full();
    test_backpressure();
    test_random_traffic();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
